>>> hw/rtl/hpwe_pkg.sv
// ----------------------------------------------------------------------------
// hpwe_pkg
// Types and constants for the histogram peak and width estimator.
// ----------------------------------------------------------------------------
package hpwe_pkg;

    // Field widths
    localparam int BIN_W     = 32;
    localparam int IDX_OUT_W = 8;
    localparam int CM_W      = 40;
    localparam int SG_W      = 41;
    localparam int TEMP_W    = 64;
    localparam int CFG_W     = 32;

    // Configuration port
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_BIN_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TEMP_SCALE = 2'd1;
    localparam logic [CFG_W-1:0]     CFG_RESET_ONE  = 32'h0001_0000;

    // e in Q16 for the 1/e test: sum * E < 3 * peak * 2^16
    localparam int E_Q16_W = 18;
    localparam logic [E_Q16_W-1:0] E_Q16 = 18'd178145;
    localparam int SUM_W  = BIN_W + 2;
    localparam int LIM_W  = SUM_W + 16;
    localparam int PRD_W  = SUM_W + E_Q16_W;

    // Shift-add steps for the multiply by temp_scale
    localparam int SCALE_STEPS = CFG_W;

    // Temperature keeps product bits [95:32], saturates above
    localparam int TEMP_LSB = 32;
    localparam int TEMP_MSB = 95;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_START,
        ST_SCAN,
        ST_CALC,
        ST_SIGN,
        ST_SQUARE,
        ST_SCALE,
        ST_FINISH
    } state_t;

endpackage

>>> hw/rtl/histogram_peak_width_estimator.sv
// Bins load at one per cycle while s_ready is high, in the load state only. After
// the transfer marked last the block scans the stored bins from peak+1 onward at
// one bin per cycle through the read port of the bin memory, then computes
// sigma^2 * temp_scale in the shift-add multiplier before the result.
// A new histogram may load while the previous result waits to be taken.
// Reset (aresetn low, synchronous) clears control state and sets both
// configuration registers to 1.0; the bin memory is not cleared.
// ----------------------------------------------------------------------------
// histogram_peak_width_estimator
// Finds the peak in bins HALF..NUM_BINS-3 of a loaded histogram and its 1/e
// edge, and reports central momentum, sigma and a saturated temperature estimate.
// ----------------------------------------------------------------------------
module histogram_peak_width_estimator #(
    parameter int NUM_BINS = 256
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    // configuration
    input  logic                                   cfg_wr_en,
    input  logic [hpwe_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [hpwe_pkg::CFG_W-1:0]             cfg_data,
    // bin input
    input  logic                                   s_valid,
    output logic                                   s_ready,
    input  logic [hpwe_pkg::BIN_W-1:0]             s_bin_value,
    input  logic                                   s_last,
    // result output
    output logic                                   m_valid,
    input  logic                                   m_ready,
    output logic [hpwe_pkg::IDX_OUT_W-1:0]         m_peak_index,
    output logic [hpwe_pkg::IDX_OUT_W-1:0]         m_edge_index,
    output logic signed [hpwe_pkg::CM_W-1:0]       m_central_momentum,
    output logic signed [hpwe_pkg::SG_W-1:0]       m_sigma,
    output logic [hpwe_pkg::TEMP_W-1:0]            m_temperature
);

    localparam int AW     = $clog2(NUM_BINS);
    localparam int CNT_W  = AW + 1;
    localparam int HALF   = NUM_BINS / 2;
    localparam int TW     = AW + 35;          // (2d+1) * bin_width
    localparam int MW     = AW + 33;          // |sigma|
    localparam int PROD_W = 2 * MW + hpwe_pkg::CFG_W;
    localparam int CW     = $clog2(MW);

    // ------------------------------------------------------------------------
    // State and registers
    // ------------------------------------------------------------------------
    hpwe_pkg::state_t state_reg, state_next;

    logic [hpwe_pkg::CFG_W-1:0]  bin_width_reg;
    logic [hpwe_pkg::CFG_W-1:0]  temp_scale_reg;

    logic [hpwe_pkg::BIN_W-1:0]  bin_mem [NUM_BINS];

    logic [CNT_W-1:0]            load_count_reg;
    logic [hpwe_pkg::BIN_W-1:0]  peak_value_reg;
    logic [AW-1:0]               peak_pos_reg;

    // scan pipeline
    logic [CNT_W-1:0]            scan_addr_reg;
    logic                        rd_v_reg;
    logic [CNT_W-1:0]            rd_addr_d_reg;
    logic [hpwe_pkg::BIN_W-1:0]  rdata_reg;
    logic [hpwe_pkg::BIN_W-1:0]  bm2_reg, bm1_reg;
    logic                        sum_v_reg;
    logic [hpwe_pkg::SUM_W-1:0]  sum_reg;
    logic [CNT_W-1:0]            sum_i_reg;
    logic                        prod_v_reg;
    logic [hpwe_pkg::PRD_W-1:0]  prod_reg;
    logic [CNT_W-1:0]            prod_i_reg;
    logic [hpwe_pkg::LIM_W-1:0]  lim_reg;
    logic                        hit_reg;
    logic [AW-1:0]               edge_reg;

    // result arithmetic
    logic signed [hpwe_pkg::CM_W-1:0] cm_reg;
    logic signed [TW-1:0]        two_s_reg;
    logic signed [TW-1:0]        sg_reg;
    logic [PROD_W-1:0]           mcand_reg;
    logic [MW-1:0]               mplier_reg;
    logic [PROD_W-1:0]           acc_reg;
    logic [CW-1:0]               mul_cnt_reg;
    logic [hpwe_pkg::TEMP_W-1:0] temp_reg;

    // output register
    logic                              m_valid_reg;
    logic [hpwe_pkg::IDX_OUT_W-1:0]    out_peak_reg;
    logic [hpwe_pkg::IDX_OUT_W-1:0]    out_edge_reg;
    logic signed [hpwe_pkg::CM_W-1:0]  out_cm_reg;
    logic signed [hpwe_pkg::SG_W-1:0]  out_sg_reg;
    logic [hpwe_pkg::TEMP_W-1:0]       out_temp_reg;

    // ------------------------------------------------------------------------
    // Control decode
    // ------------------------------------------------------------------------
    logic in_xfer;
    logic load_ok;
    logic peak_upd;
    logic scan_issue;
    logic issue_done;
    logic scan_done;
    logic sq_last;
    logic sc_last;
    logic out_free;
    logic out_load;
    logic in_scan;

    assign in_xfer    = s_valid && s_ready;
    assign load_ok    = load_count_reg < CNT_W'(NUM_BINS);
    assign peak_upd   = in_xfer && load_ok
                        && (load_count_reg >= CNT_W'(HALF))
                        && (load_count_reg <= CNT_W'(NUM_BINS - 3))
                        && (s_bin_value > peak_value_reg);
    assign issue_done = scan_addr_reg > CNT_W'(NUM_BINS - 2);
    assign scan_done  = (hit_reg || issue_done) && !rd_v_reg && !sum_v_reg && !prod_v_reg;
    assign sq_last    = mul_cnt_reg == CW'(MW - 1);
    assign sc_last    = mul_cnt_reg == CW'(hpwe_pkg::SCALE_STEPS - 1);
    assign out_free   = !m_valid_reg || m_ready;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            hpwe_pkg::ST_LOAD: begin
                if (in_xfer && s_last) begin
                    state_next = hpwe_pkg::ST_START;
                end
            end
            hpwe_pkg::ST_START:  state_next = hpwe_pkg::ST_SCAN;
            hpwe_pkg::ST_SCAN: begin
                if (scan_done) begin
                    state_next = hpwe_pkg::ST_CALC;
                end
            end
            hpwe_pkg::ST_CALC:   state_next = hpwe_pkg::ST_SIGN;
            hpwe_pkg::ST_SIGN:   state_next = hpwe_pkg::ST_SQUARE;
            hpwe_pkg::ST_SQUARE: begin
                if (sq_last) begin
                    state_next = hpwe_pkg::ST_SCALE;
                end
            end
            hpwe_pkg::ST_SCALE: begin
                if (sc_last) begin
                    state_next = hpwe_pkg::ST_FINISH;
                end
            end
            hpwe_pkg::ST_FINISH: begin
                if (out_free) begin
                    state_next = hpwe_pkg::ST_LOAD;
                end
            end
            default: state_next = hpwe_pkg::ST_LOAD;
        endcase
    end

    always_comb begin
        s_ready    = 1'b0;
        in_scan    = 1'b0;
        scan_issue = 1'b0;
        out_load   = 1'b0;
        unique case (state_reg)
            hpwe_pkg::ST_LOAD:   s_ready = 1'b1;
            hpwe_pkg::ST_SCAN: begin
                in_scan    = 1'b1;
                scan_issue = !hit_reg && !issue_done;
            end
            hpwe_pkg::ST_FINISH: out_load = out_free;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= hpwe_pkg::ST_LOAD;
        end else begin
            state_reg <= state_next;
        end
    end

    // ------------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bin_width_reg  <= hpwe_pkg::CFG_RESET_ONE;
            temp_scale_reg <= hpwe_pkg::CFG_RESET_ONE;
        end else if (cfg_wr_en) begin
            if (cfg_index == hpwe_pkg::CFG_BIN_WIDTH) begin
                bin_width_reg <= cfg_data;
            end
            if (cfg_index == hpwe_pkg::CFG_TEMP_SCALE) begin
                temp_scale_reg <= cfg_data;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Bin memory: write while loading, read while scanning
    // ------------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (in_xfer && load_ok) begin
            bin_mem[load_count_reg[AW-1:0]] <= s_bin_value;
        end
    end

    always_ff @(posedge aclk) begin
        if (scan_issue) begin
            rdata_reg <= bin_mem[scan_addr_reg[AW-1:0]];
        end
    end

    // ------------------------------------------------------------------------
    // Load tracking
    // ------------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            load_count_reg <= '0;
            peak_value_reg <= '0;
            peak_pos_reg   <= AW'(1);
        end else if (out_load) begin
            load_count_reg <= '0;
            peak_value_reg <= '0;
            peak_pos_reg   <= AW'(1);
        end else if (in_xfer && load_ok) begin
            load_count_reg <= load_count_reg + CNT_W'(1);
            if (peak_upd) begin
                peak_value_reg <= s_bin_value;
                peak_pos_reg   <= load_count_reg[AW-1:0];
            end
        end
    end

    // ------------------------------------------------------------------------
    // Edge scan: read, three-bin sum, multiply by e, compare
    // ------------------------------------------------------------------------
    logic [CNT_W:0] sum_first;
    assign sum_first = (CNT_W + 1)'(peak_pos_reg) + (CNT_W + 1)'(2);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_v_reg   <= 1'b0;
            sum_v_reg  <= 1'b0;
            prod_v_reg <= 1'b0;
            hit_reg    <= 1'b0;
        end else begin
            rd_v_reg   <= scan_issue;
            sum_v_reg  <= in_scan && rd_v_reg
                          && ((CNT_W + 1)'(rd_addr_d_reg) >= sum_first);
            prod_v_reg <= in_scan && sum_v_reg;
            if (state_reg == hpwe_pkg::ST_START) begin
                hit_reg <= 1'b0;
            end else if (in_scan && prod_v_reg && !hit_reg
                         && (hpwe_pkg::LIM_W + 2)'(prod_reg) < (hpwe_pkg::LIM_W + 2)'(lim_reg)) begin
                hit_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == hpwe_pkg::ST_START) begin
            scan_addr_reg <= CNT_W'(peak_pos_reg);
            lim_reg       <= {hpwe_pkg::SUM_W'(peak_value_reg)
                              + hpwe_pkg::SUM_W'({peak_value_reg, 1'b0}), 16'b0};
            edge_reg      <= AW'(HALF);
        end else begin
            if (scan_issue) begin
                scan_addr_reg <= scan_addr_reg + CNT_W'(1);
            end
            // first bin under the threshold: edge is one below its center
            if (in_scan && prod_v_reg && !hit_reg
                && (hpwe_pkg::LIM_W + 2)'(prod_reg) < (hpwe_pkg::LIM_W + 2)'(lim_reg)) begin
                edge_reg <= AW'(prod_i_reg - CNT_W'(1));
            end
        end
        rd_addr_d_reg <= scan_addr_reg;
        if (rd_v_reg) begin
            bm2_reg <= bm1_reg;
            bm1_reg <= rdata_reg;
        end
        sum_reg    <= hpwe_pkg::SUM_W'(bm2_reg) + hpwe_pkg::SUM_W'(bm1_reg)
                      + hpwe_pkg::SUM_W'(rdata_reg);
        sum_i_reg  <= rd_addr_d_reg - CNT_W'(1);
        prod_reg   <= hpwe_pkg::PRD_W'(sum_reg) * hpwe_pkg::PRD_W'(hpwe_pkg::E_Q16);
        prod_i_reg <= sum_i_reg;
    end

    // ------------------------------------------------------------------------
    // Result arithmetic
    // ------------------------------------------------------------------------
    logic signed [AW+1:0]  peak_s;
    logic signed [AW+1:0]  d_s;
    logic signed [AW+1:0]  odd_s;
    logic signed [TW-1:0]  bw_ext;
    logic signed [TW-1:0]  cm_full;
    logic signed [TW-1:0]  two_s_full;
    logic signed [TW-1:0]  sg_c;
    logic [MW-1:0]         mag_c;
    logic [PROD_W-1:0]     acc_add;
    logic                  temp_sat;

    assign peak_s     = signed'((AW + 2)'(peak_pos_reg));
    assign d_s        = signed'((AW + 2)'(edge_reg)) - peak_s;
    assign odd_s      = signed'({d_s[AW:0], 1'b1});
    assign bw_ext     = signed'(TW'(bin_width_reg));
    assign cm_full    = TW'(peak_s - signed'((AW + 2)'(HALF))) * bw_ext;
    assign two_s_full = TW'(odd_s) * bw_ext;
    // floor division by two
    assign sg_c       = two_s_reg >>> 1;
    assign mag_c      = sg_c[TW-1] ? MW'(-sg_c) : MW'(sg_c);
    assign acc_add    = acc_reg + (mplier_reg[0] ? mcand_reg : '0);
    assign temp_sat   = |acc_add[PROD_W-1:hpwe_pkg::TEMP_MSB+1];

    always_ff @(posedge aclk) begin
        unique case (state_reg)
            hpwe_pkg::ST_CALC: begin
                cm_reg    <= hpwe_pkg::CM_W'(cm_full);
                two_s_reg <= two_s_full;
            end
            hpwe_pkg::ST_SIGN: begin
                sg_reg      <= sg_c;
                mcand_reg   <= PROD_W'(mag_c);
                mplier_reg  <= mag_c;
                acc_reg     <= '0;
                mul_cnt_reg <= '0;
            end
            hpwe_pkg::ST_SQUARE: begin
                if (sq_last) begin
                    // square done: multiply it by temp_scale next
                    mcand_reg   <= acc_add;
                    mplier_reg  <= MW'(temp_scale_reg);
                    acc_reg     <= '0;
                    mul_cnt_reg <= '0;
                end else begin
                    acc_reg     <= acc_add;
                    mcand_reg   <= mcand_reg << 1;
                    mplier_reg  <= mplier_reg >> 1;
                    mul_cnt_reg <= mul_cnt_reg + CW'(1);
                end
            end
            hpwe_pkg::ST_SCALE: begin
                acc_reg     <= acc_add;
                mcand_reg   <= mcand_reg << 1;
                mplier_reg  <= mplier_reg >> 1;
                mul_cnt_reg <= mul_cnt_reg + CW'(1);
                if (sc_last) begin
                    temp_reg <= temp_sat ? '1
                                : acc_add[hpwe_pkg::TEMP_MSB:hpwe_pkg::TEMP_LSB];
                end
            end
            default: ;
        endcase
    end

    // ------------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            out_peak_reg <= hpwe_pkg::IDX_OUT_W'(peak_pos_reg);
            out_edge_reg <= hpwe_pkg::IDX_OUT_W'(edge_reg);
            out_cm_reg   <= cm_reg;
            out_sg_reg   <= hpwe_pkg::SG_W'(sg_reg);
            out_temp_reg <= temp_reg;
        end
    end

    assign m_valid            = m_valid_reg;
    assign m_peak_index       = out_peak_reg;
    assign m_edge_index       = out_edge_reg;
    assign m_central_momentum = out_cm_reg;
    assign m_sigma            = out_sg_reg;
    assign m_temperature      = out_temp_reg;

endmodule
